### rtl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// shared types for the sector pattern run-length decoder
// ----------------------------------------------------------------------------
package spr_pkg;

    typedef enum logic [2:0]
    {
        ST_OK       = 3'd0,
        ST_BUSY     = 3'd1,
        ST_BAD_TYPE = 3'd2,
        ST_PAT_BIG  = 3'd3,
        ST_OVERRUN  = 3'd4
    } spr_status_t;

    // queued input beat
    typedef struct packed
    {
        logic       tick;
        logic [7:0] data;
    } spr_item_t;

    // result beat, lowest field last
    typedef struct packed
    {
        logic [15:0] decoded_count;
        spr_status_t status;
        logic        record_end;
        logic        accepted;
        logic        out_valid;
        logic [7:0]  out_byte;
    } spr_result_t;

endpackage

### rtl/spr_ram.sv
// ----------------------------------------------------------------------------
// spr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/spr_front.sv
// ----------------------------------------------------------------------------
// spr_front
// input side: takes beats, tags ticks, holds them in a two-entry queue
// ----------------------------------------------------------------------------
module spr_front
    import spr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic [7:0] s_tdata,  // in_byte
    input  logic      s_tuser,   // mode
    output logic      q_valid,
    output spr_item_t q_item,
    input  logic      q_pop
);

    spr_item_t  entry_reg [2];
    logic       head_reg;
    logic       head_next;
    logic       tail_reg;
    logic       tail_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    spr_item_t  item_in;

    assign s_tready     = (count_reg != 2'd2);
    assign push         = s_tvalid && s_tready;
    assign q_valid      = (count_reg != 2'd0);
    assign pop          = q_pop && q_valid;
    assign q_item       = entry_reg[head_reg];
    assign item_in.tick = s_tuser;
    assign item_in.data = s_tuser ? 8'd0 : s_tdata;

    always_comb
    begin
        head_next  = pop ? ~head_reg : head_reg;
        tail_next  = push ? ~tail_reg : tail_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= item_in;
        end
    end

endmodule

### rtl/spr_back.sv
// ----------------------------------------------------------------------------
// spr_back
// record parser/run expander, a queued beat per cycle into result reg unless stalled
// ----------------------------------------------------------------------------
module spr_back
    import spr_pkg::*;
#(
    parameter int PATTERN_BYTES_LOG2 = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  spr_item_t   q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output spr_result_t m_result
);

    localparam int PAT_DEPTH = 1 << PATTERN_BYTES_LOG2;
    localparam int AW        = PATTERN_BYTES_LOG2;
    localparam int IDX_W     = (PATTERN_BYTES_LOG2 + 1 > 3) ? PATTERN_BYTES_LOG2 + 1 : 3;
    localparam logic [7:0] PAT_MAX = 8'(PATTERN_BYTES_LOG2);

    typedef enum logic [3:0]
    {
        PH_LEN_LO,
        PH_LEN_HI,
        PH_TYPE,
        PH_RAW,
        PH_PAIRHDR,
        PH_SUBHEAD,
        PH_SUBARG,
        PH_LIT,
        PH_PAT,
        PH_EXPAND,
        PH_DROP_EXTRA,
        PH_DROP_TYPE,
        PH_DROP_PAT,
        PH_DROP_OVER
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [1:0]  rtype_reg,   rtype_next;
    logic [15:0] payload_reg, payload_next;
    logic [15:0] run_reg,     run_next;
    logic [3:0]  log2_reg,    log2_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0] total_reg,   total_next;
    logic        m_valid_reg;
    spr_result_t result_reg,  result_next;

    logic          step;
    logic [7:0]    b;
    logic [IDX_W-1:0] size;
    logic          settle_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign step     = q_valid && (!m_valid_reg || m_tready);
    assign q_pop    = step;
    assign m_tvalid = m_valid_reg;
    assign m_result = result_reg;
    assign b        = q_item.data;
    assign size     = IDX_W'(1) << log2_reg;
    assign rd_addr  = step ? idx_next[AW-1:0] : idx_reg[AW-1:0];

    spr_ram #(
        .WIDTH (8),
        .DEPTH (PAT_DEPTH)
    ) u_pattern (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (b),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        phase_next   = phase_reg;
        rtype_next   = rtype_reg;
        payload_next = payload_reg;
        run_next     = run_reg;
        log2_next    = log2_reg;
        idx_next     = idx_reg;
        total_next   = total_reg;
        settle_en    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = idx_reg[AW-1:0];
        result_next  = '0;
        result_next.status        = ST_OK;
        result_next.decoded_count = total_reg;

        if (q_item.tick)
        begin
            if (phase_reg == PH_EXPAND)
            begin
                result_next.out_byte  = rd_data;
                result_next.out_valid = 1'b1;
                total_next = total_reg + 16'd1;
                idx_next   = idx_reg + IDX_W'(1);
                if (idx_next >= size)
                begin
                    idx_next = '0;
                    run_next = run_reg - 16'd1;
                end
                if (run_next == 16'd0)
                begin
                    phase_next = (rtype_reg == 2'd1) ? PH_DROP_EXTRA : PH_SUBHEAD;
                end
                settle_en = 1'b1;
            end
        end
        else if (phase_reg == PH_EXPAND)
        begin
            result_next.status = ST_BUSY;
        end
        else
        begin
            result_next.accepted = 1'b1;
            case (phase_reg)
                PH_LEN_LO:
                begin
                    payload_next = {8'd0, b};
                    phase_next   = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    payload_next = {b, payload_reg[7:0]} - 16'd1;
                    phase_next   = PH_TYPE;
                end
                PH_TYPE:
                begin
                    idx_next = '0;
                    case (b)
                        8'd0:
                        begin
                            rtype_next = 2'd0;
                            phase_next = PH_RAW;
                        end
                        8'd1:
                        begin
                            rtype_next = 2'd1;
                            phase_next = PH_PAIRHDR;
                        end
                        8'd2:
                        begin
                            rtype_next = 2'd2;
                            phase_next = PH_SUBHEAD;
                        end
                        default:
                        begin
                            rtype_next = 2'd3;
                            phase_next = PH_DROP_TYPE;
                        end
                    endcase
                    settle_en = 1'b1;
                end
                default:
                begin
                    payload_next = payload_reg - 16'd1;
                    settle_en    = 1'b1;
                    case (phase_reg)
                        PH_RAW:
                        begin
                            result_next.out_byte  = b;
                            result_next.out_valid = 1'b1;
                            total_next = total_reg + 16'd1;
                        end
                        PH_PAIRHDR:
                        begin
                            if (idx_reg == IDX_W'(0))
                            begin
                                run_next = {8'd0, b};
                            end
                            else if (idx_reg == IDX_W'(1))
                            begin
                                run_next = {b, run_reg[7:0]};
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(idx_reg[0]);
                            end
                            idx_next = idx_reg + IDX_W'(1);
                            if (idx_next >= IDX_W'(4))
                            begin
                                log2_next = 4'd1;
                                idx_next  = '0;
                                if (run_next != 16'd0)
                                begin
                                    phase_next = PH_EXPAND;
                                end
                                else
                                begin
                                    phase_next = (rtype_reg == 2'd1) ? PH_DROP_EXTRA
                                                                     : PH_SUBHEAD;
                                end
                            end
                        end
                        PH_SUBHEAD:
                        begin
                            if (b == 8'd0)
                            begin
                                log2_next  = 4'd0;
                                phase_next = PH_SUBARG;
                            end
                            else if (b > PAT_MAX)
                            begin
                                phase_next = PH_DROP_PAT;
                            end
                            else
                            begin
                                log2_next  = b[3:0];
                                phase_next = PH_SUBARG;
                            end
                        end
                        PH_SUBARG:
                        begin
                            run_next = {8'd0, b};
                            idx_next = '0;
                            if (log2_reg == 4'd0)
                            begin
                                if ({8'd0, b} > payload_next)
                                begin
                                    phase_next = PH_DROP_OVER;
                                end
                                else if (b == 8'd0)
                                begin
                                    phase_next = PH_SUBHEAD;
                                end
                                else
                                begin
                                    phase_next = PH_LIT;
                                end
                            end
                            else if (16'(size) > payload_next)
                            begin
                                phase_next = PH_DROP_OVER;
                            end
                            else
                            begin
                                phase_next = PH_PAT;
                            end
                        end
                        PH_LIT:
                        begin
                            result_next.out_byte  = b;
                            result_next.out_valid = 1'b1;
                            total_next = total_reg + 16'd1;
                            run_next   = run_reg - 16'd1;
                            if (run_next == 16'd0)
                            begin
                                phase_next = PH_SUBHEAD;
                            end
                        end
                        PH_PAT:
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = idx_reg[AW-1:0];
                            idx_next = idx_reg + IDX_W'(1);
                            if (idx_next >= size)
                            begin
                                idx_next = '0;
                                if (run_reg != 16'd0)
                                begin
                                    phase_next = PH_EXPAND;
                                end
                                else
                                begin
                                    phase_next = (rtype_reg == 2'd1) ? PH_DROP_EXTRA
                                                                     : PH_SUBHEAD;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            endcase
        end

        if (settle_en)
        begin
            case (phase_next)
                PH_EXPAND:    result_next.status = ST_BUSY;
                PH_DROP_TYPE: result_next.status = ST_BAD_TYPE;
                PH_DROP_PAT:  result_next.status = ST_PAT_BIG;
                PH_DROP_OVER: result_next.status = ST_OVERRUN;
                default:      result_next.status = ST_OK;
            endcase
            result_next.decoded_count = total_next;
            if (payload_next == 16'd0 && phase_next != PH_EXPAND)
            begin
                if (phase_next inside {PH_PAIRHDR, PH_SUBARG, PH_LIT, PH_PAT})
                begin
                    result_next.status = ST_OVERRUN;
                end
                phase_next             = PH_LEN_LO;
                total_next             = 16'd0;
                result_next.record_end = 1'b1;
            end
        end

        if (!step)
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEN_LO;
            rtype_reg   <= 2'd0;
            payload_reg <= 16'd0;
            run_reg     <= 16'd0;
            log2_reg    <= 4'd0;
            idx_reg     <= '0;
            total_reg   <= 16'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg   <= phase_next;
                rtype_reg   <= rtype_next;
                payload_reg <= payload_next;
                run_reg     <= run_next;
                log2_reg    <= log2_next;
                idx_reg     <= idx_next;
                total_reg   <= total_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

endmodule

### rtl/sector_pattern_rle_decoder.sv
// ----------------------------------------------------------------------------
// sector_pattern_rle_decoder
// decodes pattern run-length sector records, one encoded byte or tick per beat
//
//   channel  dir  payload
//   s_*      in   tdata[7:0] in_byte, tuser mode (1 = tick)
//   m_*      out  tdata: out_byte, accepted, status, decoded_count
//                 (low bit up, zero padded); tuser out_valid; tlast record_end
//
// one beat per cycle sustained unless m_* stalls; beats pass queue, result reg
// the back end's state update is the loop that sets the rate
// a two-entry queue sits between input and parser; the result register
// stalls the parser only while m_tready is low and a result is held
// reset is asynchronous and clears the queue, parser state and result valid
// ----------------------------------------------------------------------------
module sector_pattern_rle_decoder
    import spr_pkg::*;
#(
    parameter int PATTERN_BYTES_LOG2 = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte, accepted, status, decoded_count
    output logic        m_tuser,   // out_valid
    output logic        m_tlast    // record_end
);

    logic        q_valid;
    logic        q_pop;
    spr_item_t   q_item;
    spr_result_t result;

    spr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    spr_back #(
        .PATTERN_BYTES_LOG2 (PATTERN_BYTES_LOG2)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tdata = {4'd0, result.decoded_count, result.status, result.accepted,
                      result.out_byte};
    assign m_tuser = result.out_valid;
    assign m_tlast = result.record_end;

endmodule
